/* src/tfsd_pkg.sv */
package tfsd_pkg;

    // Type tags carried in the byte stream
    localparam logic [7:0] TAG_INT8      = 8'd1;
    localparam logic [7:0] TAG_INT16     = 8'd2;
    localparam logic [7:0] TAG_INT32     = 8'd3;
    localparam logic [7:0] TAG_INT64     = 8'd4;
    localparam logic [7:0] TAG_FLOAT     = 8'd9;
    localparam logic [7:0] TAG_DOUBLE    = 8'd10;
    localparam logic [7:0] TAG_STRING    = 8'd11;
    localparam logic [7:0] TAG_REC_START = 8'd12;
    localparam logic [7:0] TAG_REC_END   = 8'd13;

    // Result kinds
    localparam logic [1:0] KIND_NUMERIC = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Fault codes
    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_TAG      = 2'd1;
    localparam logic [1:0] FAULT_EARLYEND = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_FIELD_TOTAL     = 1'b0;
    localparam logic [0:0] REG_FIELD_TYPE_LIST = 1'b1;

    // Result queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [3:0]  field_total;
        logic [31:0] field_type_list;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [2:0]  field_number;
        logic [63:0] field_bits;
        logic [3:0]  byte_width;
        logic        string_final;
        logic [1:0]  fault_code;
    } t_result;

    // Up to two results from one byte; b only ever follows a
    typedef struct packed {
        logic    a_valid;
        logic    b_valid;
        t_result a;
        t_result b;
    } t_push;

    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
        logic                room;
    } t_queue_status;

    // Payload bytes of a numeric type code, zero for anything else
    function automatic logic [3:0] code_width(input logic [3:0] code);
        logic [3:0] w;
        case (code)
            4'd1, 4'd5:        w = 4'd1;
            4'd2, 4'd6:        w = 4'd2;
            4'd3, 4'd7, 4'd9:  w = 4'd4;
            4'd4, 4'd8, 4'd10: w = 4'd8;
            default:           w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

/* src/tfsd_if.sv */
interface tfsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buffer_end;
    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface tfsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [2:0]  field_number;
    logic [63:0] field_bits;
    logic [3:0]  byte_width;
    logic        string_final;
    logic [1:0]  fault_code;
    modport source (output valid, output item_kind, output field_number, output field_bits,
                    output byte_width, output string_final, output fault_code, input ready);
    modport sink (input valid, input item_kind, input field_number, input field_bits,
                  input byte_width, input string_final, input fault_code, output ready);
endinterface

interface tfsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/tfsd_cfg_regs.sv */
module tfsd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tfsd_cfg_if.sink          i_cfg,
    output tfsd_pkg::t_cfg    o_cfg
);

    tfsd_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tfsd_pkg::REG_FIELD_TOTAL: begin
                    r_cfg.field_total <= i_cfg.data[3:0];
                end
                tfsd_pkg::REG_FIELD_TYPE_LIST: begin
                    r_cfg.field_type_list <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/tfsd_parser.sv */
module tfsd_parser #(
    parameter int MAX_FIELDS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tfsd_in_if.sink                 i_in,
    input  tfsd_pkg::t_cfg          i_cfg,
    input  tfsd_pkg::t_queue_status i_qstat,
    output tfsd_pkg::t_push         o_push
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_TAG   = 3'd1;
    localparam logic [2:0] PH_NUM   = 3'd2;
    localparam logic [2:0] PH_SLEN  = 3'd3;
    localparam logic [2:0] PH_SDATA = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    localparam logic [3:0] MaxFieldsW = 4'(MAX_FIELDS);

    // Input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Parse state
    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_field, n_field;
    logic [3:0]  r_pcount, n_pcount;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_srem, n_srem;
    logic        r_sticky, n_sticky;
    logic [3:0]  r_lwidth, n_lwidth;

    logic            take, go;
    logic [3:0]      total;
    logic [2:0]      cf;
    logic [3:0]      code;
    logic [3:0]      cwidth;
    logic [3:0]      pc_inc;
    logic [63:0]     acc_shift;
    logic [31:0]     acc32;
    tfsd_pkg::t_push push;
    tfsd_pkg::t_result early;

    assign i_in.ready = !r_in_valid || i_qstat.room;
    assign take       = i_in.valid && i_in.ready;
    assign go         = r_in_valid && i_qstat.room;
    assign n_in_valid = take ? 1'b1 : (go ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (take) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.buffer_end;
        end
    end

    assign total     = (i_cfg.field_total > MaxFieldsW) ? MaxFieldsW : i_cfg.field_total;
    assign cf        = r_field[2:0];
    assign code      = i_cfg.field_type_list[4*cf +: 4];
    assign cwidth    = tfsd_pkg::code_width(code);
    assign pc_inc    = r_pcount + 4'd1;
    assign acc_shift = {r_acc[55:0], r_in_byte};
    assign acc32     = {r_acc[23:0], r_in_byte};

    // Per-byte state update and result generation
    always_comb begin
        n_phase  = r_phase;
        n_field  = r_field;
        n_pcount = r_pcount;
        n_acc    = r_acc;
        n_srem   = r_srem;
        n_sticky = r_sticky;
        n_lwidth = r_lwidth;
        push     = '0;
        early    = '0;

        if (go) begin
            case (r_phase)
                PH_START: begin
                    if (r_in_byte == tfsd_pkg::TAG_REC_START) begin
                        n_field = 4'd0;
                        n_phase = PH_TAG;
                    end else begin
                        push.a_valid      = 1'b1;
                        push.a.item_kind  = tfsd_pkg::KIND_ERROR;
                        push.a.fault_code = tfsd_pkg::FAULT_TAG;
                        n_sticky          = 1'b1;
                        n_phase           = PH_ERR;
                    end
                end
                PH_TAG: begin
                    if (r_field >= total) begin
                        push.a_valid = 1'b1;
                        if (r_in_byte == tfsd_pkg::TAG_REC_END) begin
                            push.a.item_kind = tfsd_pkg::KIND_DONE;
                            n_phase          = PH_DONE;
                        end else begin
                            push.a.item_kind  = tfsd_pkg::KIND_ERROR;
                            push.a.fault_code = tfsd_pkg::FAULT_TAG;
                            n_sticky          = 1'b1;
                            n_phase           = PH_ERR;
                        end
                    end else if (r_in_byte != {4'd0, code}) begin
                        push.a_valid        = 1'b1;
                        push.a.item_kind    = tfsd_pkg::KIND_ERROR;
                        push.a.field_number = cf;
                        push.a.fault_code   = tfsd_pkg::FAULT_TAG;
                        n_sticky            = 1'b1;
                        n_phase             = PH_ERR;
                    end else if (cwidth != 4'd0) begin
                        n_lwidth = cwidth;
                        n_pcount = 4'd0;
                        n_acc    = '0;
                        n_phase  = PH_NUM;
                    end else if ({4'd0, code} == tfsd_pkg::TAG_STRING) begin
                        n_pcount = 4'd0;
                        n_acc    = '0;
                        n_phase  = PH_SLEN;
                    end else begin
                        // tag-only field
                        n_field  = r_field + 4'd1;
                        n_pcount = 4'd0;
                        n_acc    = '0;
                        n_phase  = PH_TAG;
                    end
                end
                PH_NUM: begin
                    if (pc_inc >= r_lwidth) begin
                        push.a_valid        = 1'b1;
                        push.a.item_kind    = tfsd_pkg::KIND_NUMERIC;
                        push.a.field_number = cf;
                        push.a.field_bits   = acc_shift;
                        push.a.byte_width   = r_lwidth;
                        n_field             = r_field + 4'd1;
                        n_pcount            = 4'd0;
                        n_acc               = '0;
                        n_phase             = PH_TAG;
                    end else begin
                        n_acc    = acc_shift;
                        n_pcount = pc_inc;
                    end
                end
                PH_SLEN: begin
                    if (pc_inc >= 4'd4) begin
                        n_srem   = acc32;
                        n_pcount = 4'd0;
                        n_acc    = '0;
                        if (acc32 == 32'd0) begin
                            // empty string ends the field
                            n_field = r_field + 4'd1;
                            n_phase = PH_TAG;
                        end else begin
                            n_phase = PH_SDATA;
                        end
                    end else begin
                        n_acc    = {32'd0, acc32};
                        n_pcount = pc_inc;
                    end
                end
                PH_SDATA: begin
                    push.a_valid        = 1'b1;
                    push.a.item_kind    = tfsd_pkg::KIND_STRING;
                    push.a.field_number = cf;
                    push.a.field_bits   = {56'd0, r_in_byte};
                    push.a.string_final = (r_srem == 32'd1);
                    n_srem              = r_srem - 32'd1;
                    if (r_srem == 32'd1) begin
                        n_field  = r_field + 4'd1;
                        n_pcount = 4'd0;
                        n_acc    = '0;
                        n_phase  = PH_TAG;
                    end
                end
                default: begin
                end
            endcase

            // Final byte: flag an unfinished record, then start afresh
            if (r_in_end) begin
                if (n_phase != PH_DONE && n_phase != PH_ERR && !n_sticky) begin
                    early.item_kind  = tfsd_pkg::KIND_ERROR;
                    early.fault_code = tfsd_pkg::FAULT_EARLYEND;
                    if (n_phase != PH_START && n_field < total) begin
                        early.field_number = n_field[2:0];
                    end
                    if (push.a_valid) begin
                        push.b_valid = 1'b1;
                        push.b       = early;
                    end else begin
                        push.a_valid = 1'b1;
                        push.a       = early;
                    end
                end
                n_phase  = PH_START;
                n_field  = 4'd0;
                n_pcount = 4'd0;
                n_acc    = '0;
                n_srem   = '0;
                n_sticky = 1'b0;
                n_lwidth = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_field  <= 4'd0;
            r_pcount <= 4'd0;
            r_acc    <= '0;
            r_srem   <= '0;
            r_sticky <= 1'b0;
            r_lwidth <= 4'd0;
        end else begin
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_pcount <= n_pcount;
            r_acc    <= n_acc;
            r_srem   <= n_srem;
            r_sticky <= n_sticky;
            r_lwidth <= n_lwidth;
        end
    end

    assign o_push = push;

endmodule

/* src/tfsd_out_queue.sv */
module tfsd_out_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tfsd_pkg::t_push         i_push,
    tfsd_out_if.source              o_out,
    output tfsd_pkg::t_queue_status o_qstat
);

    localparam logic [tfsd_pkg::OQ_CNT_W-1:0] RoomLimit =
        tfsd_pkg::OQ_CNT_W'(tfsd_pkg::OQ_DEPTH - 2);

    tfsd_pkg::t_result r_mem [tfsd_pkg::OQ_DEPTH];

    logic [tfsd_pkg::OQ_PTR_W-1:0] r_wr, n_wr;
    logic [tfsd_pkg::OQ_PTR_W-1:0] r_rd, n_rd;
    logic [tfsd_pkg::OQ_CNT_W-1:0] r_count, n_count;
    logic [tfsd_pkg::OQ_PTR_W-1:0] wr_next;
    logic                          pop;
    tfsd_pkg::t_result             head;

    assign pop     = o_out.valid && o_out.ready;
    assign wr_next = r_wr + tfsd_pkg::OQ_PTR_W'(1);

    // Pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.a_valid) begin
            n_wr = wr_next;
        end
        if (i_push.b_valid) begin
            n_wr = r_wr + tfsd_pkg::OQ_PTR_W'(2);
        end
        if (pop) begin
            n_rd = r_rd + tfsd_pkg::OQ_PTR_W'(1);
        end
        n_count = r_count + tfsd_pkg::OQ_CNT_W'(i_push.a_valid)
                + tfsd_pkg::OQ_CNT_W'(i_push.b_valid) - tfsd_pkg::OQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[wr_next] <= i_push.b;
        end
    end

    assign head               = r_mem[r_rd];
    assign o_out.valid        = (r_count != '0);
    assign o_out.item_kind    = head.item_kind;
    assign o_out.field_number = head.field_number;
    assign o_out.field_bits   = head.field_bits;
    assign o_out.byte_width   = head.byte_width;
    assign o_out.string_final = head.string_final;
    assign o_out.fault_code   = head.fault_code;

    assign o_qstat.count = r_count;
    assign o_qstat.room  = (r_count <= RoomLimit);

endmodule

/* src/tagged_field_stream_decoder_core.sv */
// Path: a result passes through the input register, then the result queue.
// Throughput: one byte per cycle while the queue has room; the final byte of an
// unfinished buffer gives two results, and the single output port drains them
// one per cycle while its ready is high.
// Reset (synchronous, active low) returns parsing to the start tag, clears the
// result queue and sets both configuration registers to zero.
module tagged_field_stream_decoder_core #(
    parameter int MAX_FIELDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfsd_in_if.sink     i_in,
    tfsd_cfg_if.sink    i_cfg,
    tfsd_out_if.source  o_out
);

    tfsd_pkg::t_cfg          w_cfg;
    tfsd_pkg::t_push         w_push;
    tfsd_pkg::t_queue_status w_qstat;

    tfsd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    tfsd_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push)
    );

    tfsd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_out   (o_out),
        .o_qstat (w_qstat)
    );

    // Queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qstat.count + 3'(w_push.a_valid) + 3'(w_push.b_valid)
            <= 3'(tfsd_pkg::OQ_DEPTH)))
        else $error("result queue overflow");

    // Second result only ever follows a first one
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.b_valid |-> w_push.a_valid)
        else $error("second result without first");

    // Fault code present exactly on error results
    a_fault_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.item_kind == tfsd_pkg::KIND_ERROR)
            == (o_out.fault_code != tfsd_pkg::FAULT_NONE)))
        else $error("fault code inconsistent with kind");

endmodule
